/* src/hlr_pkg.sv */
package hlr_pkg;

  localparam int unsigned MAP_DEPTH_DEF = 4096;
  localparam int unsigned ID_W          = 32;
  localparam int unsigned LINK_W        = 16;

  localparam logic [LINK_W-1:0] NO_CHAIN      = 16'hffff;
  localparam logic [ID_W-1:0]   DISABLED_ZERO = 32'hfffffffe;

endpackage

/* src/hashed_lru_id_remap_table.sv */
// Passthrough results come straight from idle; a mapped hit or fill reads the home slot,
// walks its chain on a hit, then updates the LRU ring; an eviction relinks chains after any walk.
// One transaction at a time; the walk reads slot_id and chain_next for each chain slot visited.
// Reset: a clearing pass over all MAP_DEPTH slots initializes all six tables; busy is high.
// The result strobe lasts one cycle; the receiver cannot stall.
module hashed_lru_id_remap_table #(
  parameter int unsigned MAP_DEPTH = hlr_pkg::MAP_DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [hlr_pkg::ID_W-1:0] long_id_i,
  output logic                     done_o,
  output logic [hlr_pkg::ID_W-1:0] short_id_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic                     mapping_enable_i
);

  localparam int unsigned AW = $clog2(MAP_DEPTH);
  localparam int unsigned LW = hlr_pkg::LINK_W;
  localparam int unsigned IW = hlr_pkg::ID_W;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_HEAD, S_HEAD_W, S_WALK, S_WALK_W,
    S_MN1, S_MN2, S_MN3, S_MN4, S_MN5, S_MN6,
    S_EV1, S_EV2, S_EV3, S_EV4, S_EV5, S_EV6, S_EV7, S_EV8
  } state_e;

  // Map a stored link to a slot; out-of-range links read as slot zero.
  function automatic logic [AW-1:0] ix(input logic [LW-1:0] v);
    logic [LW:0] w;
    w = {1'b0, v};
    return (w < (LW+1)'(MAP_DEPTH)) ? v[AW-1:0] : '0;
  endfunction

  // Home slot: low half, else high half, else last slot; minus two, 0 and 1 to last, last-1.
  function automatic logic [AW-1:0] home(input logic [IW-1:0] id);
    logic [16:0] h;
    h = {1'b0, id[15:0]};
    if (h >= 17'(MAP_DEPTH)) begin
      h = {1'b0, id[31:16]};
      if (h >= 17'(MAP_DEPTH)) begin
        h = 17'(MAP_DEPTH - 1);
      end
    end
    if (h >= 17'd2) begin
      h = h - 17'd2;
    end else begin
      h = 17'(MAP_DEPTH - 1) - h;
    end
    return h[AW-1:0];
  endfunction

  state_e          state_q;
  logic            en_q;
  logic [IW-1:0]   id_q;
  logic [AW-1:0]   si_q, cur_q, hf_q, hit_q, old_q, n_q, p_q, oh_q, h_q, f_q, clr_q;
  logic [AW:0]     steps_q;
  logic [LW-1:0]   oldest_q;
  logic            done_q;
  logic [IW-1:0]   short_q;

  // Memory ports.
  logic          sid_we, hd_we, cp_we, cn_we, ap_we, an_we;
  logic [AW-1:0] sid_wa, hd_wa, cp_wa, cn_wa, ap_wa, an_wa;
  logic [AW-1:0] sid_ra, hd_ra, cp_ra, cn_ra, ap_ra, an_ra;
  logic [IW-1:0] sid_wd, sid_rd;
  logic [LW-1:0] hd_wd, cp_wd, cn_wd, ap_wd, an_wd;
  logic [LW-1:0] hd_rd, cp_rd, cn_rd, ap_rd, an_rd;

  logic [AW-1:0] old_slot, nxt;
  logic [AW:0]   steps_inc;
  logic          fill;

  assign old_slot  = ix(oldest_q);
  assign nxt       = ix(cn_rd);
  assign steps_inc = steps_q + (AW+1)'(1);
  assign fill      = (hd_rd == hlr_pkg::NO_CHAIN) && (sid_rd == '0);

  hlr_ram #(.WIDTH(IW), .DEPTH(MAP_DEPTH)) u_slot_id (
    .clk_i, .we_i(sid_we), .waddr_i(sid_wa), .wdata_i(sid_wd), .raddr_i(sid_ra), .rdata_o(sid_rd)
  );
  hlr_ram #(.WIDTH(LW), .DEPTH(MAP_DEPTH)) u_chain_head (
    .clk_i, .we_i(hd_we), .waddr_i(hd_wa), .wdata_i(hd_wd), .raddr_i(hd_ra), .rdata_o(hd_rd)
  );
  hlr_ram #(.WIDTH(LW), .DEPTH(MAP_DEPTH)) u_chain_prev (
    .clk_i, .we_i(cp_we), .waddr_i(cp_wa), .wdata_i(cp_wd), .raddr_i(cp_ra), .rdata_o(cp_rd)
  );
  hlr_ram #(.WIDTH(LW), .DEPTH(MAP_DEPTH)) u_chain_next (
    .clk_i, .we_i(cn_we), .waddr_i(cn_wa), .wdata_i(cn_wd), .raddr_i(cn_ra), .rdata_o(cn_rd)
  );
  hlr_ram #(.WIDTH(LW), .DEPTH(MAP_DEPTH)) u_age_prev (
    .clk_i, .we_i(ap_we), .waddr_i(ap_wa), .wdata_i(ap_wd), .raddr_i(ap_ra), .rdata_o(ap_rd)
  );
  hlr_ram #(.WIDTH(LW), .DEPTH(MAP_DEPTH)) u_age_next (
    .clk_i, .we_i(an_we), .waddr_i(an_wa), .wdata_i(an_wd), .raddr_i(an_ra), .rdata_o(an_rd)
  );

  // Memory port control: the reads and writes of each state.
  always_comb begin
    sid_we = 1'b0; hd_we = 1'b0; cp_we = 1'b0; cn_we = 1'b0; ap_we = 1'b0; an_we = 1'b0;
    sid_wa = '0; hd_wa = '0; cp_wa = '0; cn_wa = '0; ap_wa = '0; an_wa = '0;
    sid_wd = '0; hd_wd = '0; cp_wd = '0; cn_wd = '0; ap_wd = '0; an_wd = '0;
    sid_ra = '0; hd_ra = '0; cp_ra = '0; cn_ra = '0; ap_ra = '0; an_ra = '0;
    case (state_q)
      S_CLEAR: begin
        // Write empty slots, no chains, self links and the initial age ring.
        sid_we = 1'b1; hd_we = 1'b1; cp_we = 1'b1; cn_we = 1'b1; ap_we = 1'b1; an_we = 1'b1;
        sid_wa = clr_q; hd_wa = clr_q; cp_wa = clr_q; cn_wa = clr_q;
        ap_wa = clr_q; an_wa = clr_q;
        hd_wd = hlr_pkg::NO_CHAIN;
        cp_wd = LW'(clr_q);
        cn_wd = LW'(clr_q);
        ap_wd = (clr_q == '0) ? LW'(MAP_DEPTH - 1) : LW'(clr_q) - LW'(1);
        an_wd = (clr_q == AW'(MAP_DEPTH - 1)) ? '0 : LW'(clr_q) + LW'(1);
      end
      S_HEAD: begin
        sid_ra = si_q;
        hd_ra  = si_q;
      end
      S_HEAD_W: begin
        // Fill an empty home slot that heads no chain.
        if (fill) begin
          sid_we = 1'b1; sid_wa = si_q; sid_wd = id_q;
          hd_we  = 1'b1; hd_wa  = si_q; hd_wd  = LW'(si_q);
          cp_we  = 1'b1; cp_wa  = si_q; cp_wd  = LW'(si_q);
          cn_we  = 1'b1; cn_wa  = si_q; cn_wd  = LW'(si_q);
        end
      end
      S_WALK: begin
        sid_ra = cur_q;
        cn_ra  = cur_q;
      end
      S_MN1: begin
        ap_ra = old_slot;
        an_ra = hit_q;
      end
      S_MN2: begin
        ap_ra = hit_q;
      end
      S_MN3: begin
        // Unlink the slot from the age ring.
        ap_we = 1'b1; ap_wa = n_q;        ap_wd = LW'(ix(ap_rd));
        an_we = 1'b1; an_wa = ix(ap_rd);  an_wd = LW'(n_q);
      end
      S_MN4: begin
        ap_ra = old_q;
      end
      S_MN5: begin
        ap_we = 1'b1; ap_wa = hit_q; ap_wd = LW'(ix(ap_rd));
        an_we = 1'b1; an_wa = hit_q; an_wd = LW'(old_q);
      end
      S_MN6: begin
        // Insert just before the oldest slot, i.e. as the newest.
        an_we = 1'b1; an_wa = p_q;   an_wd = LW'(hit_q);
        ap_we = 1'b1; ap_wa = old_q; ap_wd = LW'(hit_q);
      end
      S_EV1: begin
        sid_ra = old_slot;
        an_ra  = old_slot;
        cp_ra  = old_slot;
        cn_ra  = old_slot;
      end
      S_EV2: begin
        sid_we = 1'b1; sid_wa = hit_q; sid_wd = id_q;
      end
      S_EV3: begin
        // Unlink the victim from its old chain.
        cp_we = 1'b1; cp_wa = n_q; cp_wd = LW'(p_q);
        cn_we = 1'b1; cn_wa = p_q; cn_wd = LW'(n_q);
        hd_ra = oh_q;
      end
      S_EV4: begin
        if (hd_rd == LW'(hit_q)) begin
          hd_we = 1'b1;
          hd_wa = oh_q;
          hd_wd = (n_q == hit_q) ? hlr_pkg::NO_CHAIN : LW'(n_q);
        end
      end
      S_EV5: begin
        hd_ra = h_q;
      end
      S_EV6: begin
        if (hd_rd == hlr_pkg::NO_CHAIN) begin
          cp_we = 1'b1; cp_wa = hit_q; cp_wd = LW'(hit_q);
          cn_we = 1'b1; cn_wa = hit_q; cn_wd = LW'(hit_q);
          hd_we = 1'b1; hd_wa = h_q;   hd_wd = LW'(hit_q);
        end else begin
          cp_ra = ix(hd_rd);
        end
      end
      S_EV7: begin
        cp_we = 1'b1; cp_wa = f_q;       cp_wd = LW'(hit_q);
        cn_we = 1'b1; cn_wa = ix(cp_rd); cn_wd = LW'(hit_q);
      end
      S_EV8: begin
        // Push the victim in front of the new chain.
        cp_we = 1'b1; cp_wa = hit_q; cp_wd = LW'(p_q);
        cn_we = 1'b1; cn_wa = hit_q; cn_wd = LW'(f_q);
        hd_we = 1'b1; hd_wa = h_q;   hd_wd = LW'(hit_q);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      en_q     <= 1'b0;
      oldest_q <= '0;
      clr_q    <= '0;
      done_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (cfg_valid_i) begin
        en_q <= mapping_enable_i;
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(MAP_DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            id_q <= long_id_i;
            si_q <= home(long_id_i);
            if (!en_q) begin
              done_q  <= 1'b1;
              short_q <= (long_id_i[15:0] != '0) ? long_id_i : hlr_pkg::DISABLED_ZERO;
            end else if (long_id_i[IW-1:1] == '0) begin
              // Identifiers zero and one pass through untouched.
              done_q  <= 1'b1;
              short_q <= long_id_i;
            end else begin
              state_q <= S_HEAD;
            end
          end
        end
        S_HEAD: begin
          state_q <= S_HEAD_W;
        end
        S_HEAD_W: begin
          if (hd_rd == hlr_pkg::NO_CHAIN) begin
            if (sid_rd == '0) begin
              hit_q   <= si_q;
              state_q <= S_MN1;
            end else begin
              state_q <= S_EV1;
            end
          end else begin
            cur_q   <= ix(hd_rd);
            hf_q    <= ix(hd_rd);
            steps_q <= '0;
            state_q <= S_WALK;
          end
        end
        S_WALK: begin
          state_q <= S_WALK_W;
        end
        S_WALK_W: begin
          if (sid_rd == id_q) begin
            hit_q   <= cur_q;
            state_q <= S_MN1;
          end else if (nxt == hf_q || steps_inc == (AW+1)'(MAP_DEPTH)) begin
            state_q <= S_EV1;
          end else begin
            cur_q   <= nxt;
            steps_q <= steps_inc;
            state_q <= S_WALK;
          end
        end
        S_MN1: begin
          old_q   <= old_slot;
          state_q <= S_MN2;
        end
        S_MN2: begin
          if (hit_q == old_q) begin
            oldest_q <= an_rd;
            done_q   <= 1'b1;
            short_q  <= IW'(hit_q) + IW'(2);
            state_q  <= S_IDLE;
          end else if (ap_rd == LW'(hit_q)) begin
            // Already the newest: leave the ring alone.
            done_q  <= 1'b1;
            short_q <= IW'(hit_q) + IW'(2);
            state_q <= S_IDLE;
          end else begin
            n_q     <= ix(an_rd);
            state_q <= S_MN3;
          end
        end
        S_MN3: begin
          state_q <= S_MN4;
        end
        S_MN4: begin
          state_q <= S_MN5;
        end
        S_MN5: begin
          p_q     <= ix(ap_rd);
          state_q <= S_MN6;
        end
        S_MN6: begin
          done_q  <= 1'b1;
          short_q <= IW'(hit_q) + IW'(2);
          state_q <= S_IDLE;
        end
        S_EV1: begin
          hit_q   <= old_slot;
          state_q <= S_EV2;
        end
        S_EV2: begin
          oldest_q <= an_rd;
          oh_q     <= home(sid_rd);
          h_q      <= home(id_q);
          p_q      <= ix(cp_rd);
          n_q      <= ix(cn_rd);
          state_q  <= S_EV3;
        end
        S_EV3: begin
          state_q <= S_EV4;
        end
        S_EV4: begin
          state_q <= S_EV5;
        end
        S_EV5: begin
          state_q <= S_EV6;
        end
        S_EV6: begin
          if (hd_rd == hlr_pkg::NO_CHAIN) begin
            done_q  <= 1'b1;
            short_q <= IW'(hit_q) + IW'(2);
            state_q <= S_IDLE;
          end else begin
            f_q     <= ix(hd_rd);
            state_q <= S_EV7;
          end
        end
        S_EV7: begin
          p_q     <= ix(cp_rd);
          state_q <= S_EV8;
        end
        S_EV8: begin
          done_q  <= 1'b1;
          short_q <= IW'(hit_q) + IW'(2);
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign short_id_o  = short_q;

endmodule

/* src/hlr_ram.sv */
module hlr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* dv/hlr_checker.sv */
`timescale 1ns / 100ps

module hlr_checker #(
  parameter int unsigned MAP_DEPTH = hlr_pkg::MAP_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [31:0] long_id_i,
  input  logic        done_i,
  input  logic [31:0] short_id_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        mapping_enable_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  logic [31:0] slot_tab [MAP_DEPTH];
  logic [15:0] head_tab [MAP_DEPTH];
  logic [15:0] cprev_tab [MAP_DEPTH];
  logic [15:0] cnext_tab [MAP_DEPTH];
  logic [15:0] aprev_tab [MAP_DEPTH];
  logic [15:0] anext_tab [MAP_DEPTH];
  logic [15:0] oldest;
  logic        map_en;
  logic [31:0] short_id_q [$];

  assign pending_o = short_id_q.size();

  function automatic int unsigned wrap_ix(input logic [15:0] v);
    return (v < MAP_DEPTH) ? int'(v) : 0;
  endfunction

  function automatic int unsigned home_of(input logic [31:0] id);
    int unsigned h;
    h = id[15:0];
    if (h >= MAP_DEPTH) begin
      h = id[31:16];
      if (h >= MAP_DEPTH) h = MAP_DEPTH - 1;
    end
    return (h >= 2) ? h - 2 : MAP_DEPTH - 1 - h;
  endfunction

  // Move slot s off its old chain and push it in front of its new one.
  function automatic void chain_relink(input int unsigned s, input logic [31:0] old_id);
    int unsigned h, oh, p, n, f;
    h  = home_of(slot_tab[s]);
    oh = home_of(old_id);
    p  = wrap_ix(cprev_tab[s]);
    n  = wrap_ix(cnext_tab[s]);
    cprev_tab[n] = 16'(p);
    cnext_tab[p] = 16'(n);
    if (head_tab[oh] == s) head_tab[oh] = (n == s) ? hlr_pkg::NO_CHAIN : 16'(n);
    if (head_tab[h] == hlr_pkg::NO_CHAIN) begin
      cprev_tab[s] = 16'(s);
      cnext_tab[s] = 16'(s);
    end else begin
      f = wrap_ix(head_tab[h]);
      p = wrap_ix(cprev_tab[f]);
      cprev_tab[f] = 16'(s);
      cnext_tab[p] = 16'(s);
      cprev_tab[s] = 16'(p);
      cnext_tab[s] = 16'(f);
    end
    head_tab[h] = 16'(s);
  endfunction

  function automatic void age_bump(input int unsigned s);
    int unsigned old, p, n;
    old = wrap_ix(oldest);
    if (s == old) begin
      oldest = anext_tab[s];
    end else if (s != aprev_tab[old]) begin
      p = wrap_ix(aprev_tab[s]);
      n = wrap_ix(anext_tab[s]);
      aprev_tab[n] = 16'(p);
      anext_tab[p] = 16'(n);
      p = wrap_ix(aprev_tab[old]);
      aprev_tab[s] = 16'(p);
      anext_tab[s] = 16'(old);
      anext_tab[p] = 16'(s);
      aprev_tab[old] = 16'(s);
    end
  endfunction

  function automatic logic [31:0] remap_id(input logic [31:0] id);
    int unsigned si, hf, cur, hit, steps;
    logic found, stop;
    logic [31:0] old_id;
    found = 1'b0;
    stop  = 1'b0;
    hit   = 0;
    if (!map_en) return (id[15:0] != 0) ? id : hlr_pkg::DISABLED_ZERO;
    if (id == 0 || id == 1) return id;
    si = home_of(id);
    if (head_tab[si] == hlr_pkg::NO_CHAIN) begin
      if (slot_tab[si] == 0) begin
        slot_tab[si]  = id;
        head_tab[si]  = 16'(si);
        cnext_tab[si] = 16'(si);
        cprev_tab[si] = 16'(si);
        hit   = si;
        found = 1'b1;
      end
    end else begin
      hf  = wrap_ix(head_tab[si]);
      cur = hf;
      for (steps = 0; steps < MAP_DEPTH && !stop; steps++) begin
        if (slot_tab[cur] == id) begin
          hit   = cur;
          found = 1'b1;
          stop  = 1'b1;
        end else begin
          cur = wrap_ix(cnext_tab[cur]);
          if (cur == hf) stop = 1'b1;
        end
      end
    end
    if (found) begin
      age_bump(hit);
    end else begin
      hit    = wrap_ix(oldest);
      oldest = anext_tab[hit];
      old_id = slot_tab[hit];
      slot_tab[hit] = id;
      chain_relink(hit, old_id);
    end
    return 32'(hit + 2);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [31:0] want;
    if (!rst_ni) begin
      for (int unsigned i = 0; i < MAP_DEPTH; i++) begin
        slot_tab[i]  = '0;
        head_tab[i]  = hlr_pkg::NO_CHAIN;
        cprev_tab[i] = 16'(i);
        cnext_tab[i] = 16'(i);
        aprev_tab[i] = 16'((i == 0) ? MAP_DEPTH - 1 : i - 1);
        anext_tab[i] = 16'((i == MAP_DEPTH - 1) ? 0 : i + 1);
      end
      oldest = '0;
      map_en = 1'b0;
      short_id_q.delete();
      fail_count_o = 0;
    end else begin
      // Retire the result first: it belongs to an earlier transaction.
      if (done_i) begin
        if (short_id_q.size() == 0) begin
          $display("%0t: unexpected result short_id=%h", $time, short_id_i);
          fail_count_o++;
        end else begin
          want = short_id_q.pop_front();
          if (want !== short_id_i) begin
            $display("%0t: short_id mismatch expected=%h actual=%h", $time, want, short_id_i);
            fail_count_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) map_en = mapping_enable_i;
      if (start_i && !busy_i) short_id_q.push_back(remap_id(long_id_i));
    end
  end

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps

module tb;

  localparam int unsigned CYCLE_LIMIT = 1000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] long_id_i = '0;
  logic        done_o;
  logic [31:0] short_id_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        mapping_enable_i = 1'b0;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_cnt = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  hashed_lru_id_remap_table dut (
    .clk_i, .rst_ni, .start, .busy, .long_id_i, .done_o, .short_id_o,
    .cfg_valid_i, .cfg_ready_o, .mapping_enable_i
  );

  hlr_checker checker_i (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .long_id_i, .done_i(done_o),
    .short_id_i(short_id_o), .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .mapping_enable_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Watchdog: the reset clearing pass plus all transactions fit far below this.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("hashed_lru_id_remap_table verification failed");
      $finish;
    end
  end

  // Hold valid until the register write transaction completes, then drop it.
  task automatic write_mapping(input logic en);
    @(negedge clk_i);
    cfg_valid_i      <= 1'b1;
    mapping_enable_i <= en;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Drain all outstanding results before touching the register.
  task automatic wait_drained();
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Present one id and hold start until the block takes it. Start stays
  // high into the next item unless the idle draw inserts a gap.
  task automatic send_id(input logic [31:0] id, input int unsigned idle_pct);
    int unsigned gap;
    start     <= 1'b1;
    long_id_i <= id;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    if ($urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      gap = $urandom_range(6, 1);
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Mostly ids crowded onto a few hash chains so hits, collisions and
  // evictions all occur; the rest walk the high-half route, the
  // passthrough pair and the full 32-bit range.
  function automatic logic [31:0] pick_id();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 55) return {16'($urandom_range(7, 0)), 16'($urandom_range(40, 0))};
    if (r < 72) return {16'($urandom_range(40, 0)), 16'($urandom_range(16'hffff, 16'h1000))};
    if (r < 80) return 32'($urandom_range(1, 0));
    return $urandom();
  endfunction

  task automatic run_random(input int unsigned n, input int unsigned idle_pct);
    for (int unsigned k = 0; k < n; k++) begin
      // Insert a stretch with no idling now and then.
      send_id(pick_id(), ((k / 50) % 3 == 2) ? 0 : idle_pct);
    end
    start <= 1'b0;
  endtask

  initial begin
    logic [31:0] dir_off [6];
    logic [31:0] dir_on [19];
    dir_off = '{32'h0, 32'h1, 32'h0001_0000, 32'hffff_ffff, 32'h1234_0000, 32'h0000_0005};
    // Passthrough pair, both hash routes, the wrap of low hashes, the
    // saturated hash, repeat hits and collisions on one chain.
    dir_on  = '{32'h0, 32'h1, 32'h2, 32'h3, 32'h0000_0fff, 32'h0005_0000,
                32'h0123_ffff, 32'hffff_ffff, 32'h0001_0001, 32'h0000_0005,
                32'h0001_0005, 32'h0002_0005, 32'h0003_0005, 32'h0000_0005,
                32'h0002_0005, 32'h0123_ffff, 32'h0000_1000, 32'hffff_1000,
                32'h0002};

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: passthrough rule first, then the mapped path.
    foreach (dir_off[i]) send_id(dir_off[i], 0);
    start <= 1'b0;
    wait_drained();
    write_mapping(1'b1);
    foreach (dir_on[i]) send_id(dir_on[i], 0);
    start <= 1'b0;

    // Random phases: sender idles 14%, then 55% with mapping off, then never.
    run_random(420, 14);
    wait_drained();
    write_mapping(1'b0);
    run_random(150, 55);
    wait_drained();
    write_mapping(1'b1);
    run_random(560, 0);

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("hashed_lru_id_remap_table verification clean");
    end else begin
      $display("hashed_lru_id_remap_table verification failed");
    end
    $finish;
  end

endmodule
